// ===== hdl/gbm_pkg.sv =====
// Package for the grid bounding-box margin mask block.
// Holds item and configuration types, op codes and register indexes.
// No dependencies.
`default_nettype none

package gbm_pkg;

  localparam int COORD_W  = 6;
  localparam int EXTENT_W = 7;
  localparam int MARGIN_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_X_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_X_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Y_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Y_HIGH = 3'd5;

  localparam logic [COORD_W-1:0] BOX_MIN_RST = 6'd63;
  localparam logic [COORD_W-1:0] BOX_MAX_RST = 6'd0;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               occupied;
  } in_item_t;

  typedef struct packed {
    logic mask_bit;
    logic box_empty;
  } out_item_t;

  typedef struct packed {
    logic [EXTENT_W-1:0] grid_width;
    logic [EXTENT_W-1:0] grid_height;
    logic [MARGIN_W-1:0] margin_x_low;
    logic [MARGIN_W-1:0] margin_x_high;
    logic [MARGIN_W-1:0] margin_y_low;
    logic [MARGIN_W-1:0] margin_y_high;
  } cfg_t;

  typedef struct packed {
    logic found;
    logic hit;
  } box_stat_t;

endpackage

`default_nettype wire

// ===== hdl/gbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gbm_cfg.sv =====
// Configuration registers of the grid bounding-box margin mask block.
// Depends on gbm_pkg.
`default_nettype none

module gbm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [gbm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [gbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output gbm_pkg::cfg_t                         cfg
);
  import gbm_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GRID_WIDTH:    cfg_nxt.grid_width    = cfg_wdata;
        CFG_GRID_HEIGHT:   cfg_nxt.grid_height   = cfg_wdata;
        CFG_MARGIN_X_LOW:  cfg_nxt.margin_x_low  = cfg_wdata[MARGIN_W-1:0];
        CFG_MARGIN_X_HIGH: cfg_nxt.margin_x_high = cfg_wdata[MARGIN_W-1:0];
        CFG_MARGIN_Y_LOW:  cfg_nxt.margin_y_low  = cfg_wdata[MARGIN_W-1:0];
        CFG_MARGIN_Y_HIGH: cfg_nxt.margin_y_high = cfg_wdata[MARGIN_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width    <= 7'd64;
      cfg_r.grid_height   <= 7'd64;
      cfg_r.margin_x_low  <= 4'd1;
      cfg_r.margin_x_high <= 4'd1;
      cfg_r.margin_y_low  <= 4'd1;
      cfg_r.margin_y_high <= 4'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/gbm_box.sv =====
// Running bounding box of occupied cells and the widened-box test for queries.
// Depends on gbm_pkg.
`default_nettype none

module gbm_box (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gbm_pkg::cfg_t               cfg,
  input  wire logic                        box_clr,
  input  wire logic                        box_upd,
  input  wire logic [gbm_pkg::COORD_W-1:0] cell_x,
  input  wire logic [gbm_pkg::COORD_W-1:0] cell_y,
  output gbm_pkg::box_stat_t               stat
);
  import gbm_pkg::*;

  logic [COORD_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [COORD_W-1:0] min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;
  logic               found_r, found_nxt;
  logic [COORD_W:0]   lo_x, hi_x, lo_y, hi_y;

  always_comb begin
    min_x_nxt = min_x_r;
    max_x_nxt = max_x_r;
    min_y_nxt = min_y_r;
    max_y_nxt = max_y_r;
    found_nxt = found_r;
    priority if (box_clr) begin
      min_x_nxt = BOX_MIN_RST;
      max_x_nxt = BOX_MAX_RST;
      min_y_nxt = BOX_MIN_RST;
      max_y_nxt = BOX_MAX_RST;
      found_nxt = 1'b0;
    end else if (box_upd) begin
      if (!found_r || cell_x < min_x_r) min_x_nxt = cell_x;
      if (!found_r || cell_x > max_x_r) max_x_nxt = cell_x;
      if (!found_r || cell_y < min_y_r) min_y_nxt = cell_y;
      if (!found_r || cell_y > max_y_r) max_y_nxt = cell_y;
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= BOX_MIN_RST;
      max_x_r <= BOX_MAX_RST;
      min_y_r <= BOX_MIN_RST;
      max_y_r <= BOX_MAX_RST;
      found_r <= 1'b0;
    end else begin
      min_x_r <= min_x_nxt;
      max_x_r <= max_x_nxt;
      min_y_r <= min_y_nxt;
      max_y_r <= max_y_nxt;
      found_r <= found_nxt;
    end
  end

  // low margins move to the query side so nothing goes below zero
  assign lo_x = {1'b0, cell_x} + {3'b000, cfg.margin_x_low};
  assign hi_x = {1'b0, max_x_r} + {3'b000, cfg.margin_x_high};
  assign lo_y = {1'b0, cell_y} + {3'b000, cfg.margin_y_low};
  assign hi_y = {1'b0, max_y_r} + {3'b000, cfg.margin_y_high};

  assign stat.found = found_r;
  assign stat.hit   = found_r
                      && (lo_x >= {1'b0, min_x_r}) && ({1'b0, cell_x} <= hi_x)
                      && (lo_y >= {1'b0, min_y_r}) && ({1'b0, cell_y} <= hi_y);

endmodule

`default_nettype wire

// ===== hdl/grid_bbox_margin_mask_unit.sv =====
// A query item passes the map read register and then the result register; out_stall can
// hold it in the map read stage while the result register still holds an untaken result.
// Throughput: one item per cycle; input stalls only while both stages hold a query
// item and out_stall is high. Clear and load items give no result; op code 3 is dropped.
// Reset (rst_n low, synchronous) clears the box and valid flags and sets config registers to defaults;
// occupancy RAM contents stay undefined until written. Depends on gbm_pkg, gbm_cfg, gbm_box, gbm_ram.
`default_nettype none

module grid_bbox_margin_mask_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire gbm_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output gbm_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [gbm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [gbm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gbm_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  cfg_t      cfg;
  box_stat_t box_stat;

  logic          acc, acc_clear, acc_load, acc_query, in_grid;
  logic [AW-1:0] addr;
  logic          map_bit;

  logic      s1_valid_r, s1_valid_nxt;
  logic      s1_qual_r, s1_empty_r;
  logic      s1_adv;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  gbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign acc       = in_valid && !in_stall;
  assign acc_clear = acc && (in_data.op == OP_CLEAR);
  assign acc_load  = acc && (in_data.op == OP_LOAD) && in_grid;
  assign acc_query = acc && (in_data.op == OP_QUERY);

  assign in_grid = (32'(in_data.cell_x) < 32'(cfg.grid_width))
                   && (32'(in_data.cell_x) < MAX_WIDTH)
                   && (32'(in_data.cell_y) < 32'(cfg.grid_height))
                   && (32'(in_data.cell_y) < MAX_HEIGHT);

  assign addr = AW'(32'(in_data.cell_x) * MAX_HEIGHT + 32'(in_data.cell_y));

  gbm_box u_box (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .box_clr (acc_clear),
    .box_upd (acc_load && in_data.occupied),
    .cell_x  (in_data.cell_x),
    .cell_y  (in_data.cell_y),
    .stat    (box_stat)
  );

  gbm_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (acc_load),
    .waddr (addr),
    .wdata (in_data.occupied),
    .re    (acc_query),
    .raddr (addr),
    .rdata (map_bit)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = acc_query;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_query) begin
      s1_qual_r  <= box_stat.hit && in_grid;
      s1_empty_r <= !box_stat.found;
    end
    if (s1_adv) begin
      out_data_r.mask_bit  <= s1_qual_r && !map_bit;
      out_data_r.box_empty <= s1_empty_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_mask_implies_box : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.mask_bit && out_data.box_empty))
    else $error("mask bit set while box is empty");

  a_query_enters_stage : assert property (@(posedge clk) disable iff (!rst_n)
    acc_query |=> s1_valid_r)
    else $error("accepted query item lost before result stage");

  a_clear_empties_box : assert property (@(posedge clk) disable iff (!rst_n)
    acc_clear |=> !box_stat.found)
    else $error("box still found after clear");

  a_stage_moves_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result stage advanced without output valid");
`endif

endmodule

`default_nettype wire

// ===== bench/bbox_mask_checker.sv =====
// Checker for the grid bounding-box margin mask unit: tracks config writes,
// predicts each query result and compares it with what the block returns.
// Depends on gbm_pkg.
`timescale 1ns / 1ps

module bbox_mask_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  gbm_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  gbm_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [gbm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             results_due
);
  import gbm_pkg::*;

  bit                 cell_occ [0:63][0:63];
  logic [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic               found;
  cfg_t               regs;
  out_item_t          pending_masks [$];
  int                 fail_cnt = 0;

  task automatic clear_box();
    min_x = BOX_MIN_RST;
    max_x = BOX_MAX_RST;
    min_y = BOX_MIN_RST;
    max_y = BOX_MAX_RST;
    found = 1'b0;
  endtask

  function automatic bit on_grid(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int w, h;
    w = (regs.grid_width > 64) ? 64 : int'(regs.grid_width);
    h = (regs.grid_height > 64) ? 64 : int'(regs.grid_height);
    return (int'(x) < w) && (int'(y) < h);
  endfunction

  function automatic out_item_t predict_mask(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
    out_item_t r;
    bit        near;
    r.box_empty = !found;
    r.mask_bit  = 1'b0;
    if (found && on_grid(x, y)) begin
      near = (int'(x) + int'(regs.margin_x_low) >= int'(min_x)) &&
             (int'(x) <= int'(max_x) + int'(regs.margin_x_high)) &&
             (int'(y) + int'(regs.margin_y_low) >= int'(min_y)) &&
             (int'(y) <= int'(max_y) + int'(regs.margin_y_high));
      r.mask_bit = near && !cell_occ[x][y];
    end
    return r;
  endfunction

  task automatic apply_item(input in_item_t it);
    case (it.op)
      OP_CLEAR: clear_box();
      OP_LOAD: begin
        if (on_grid(it.cell_x, it.cell_y)) begin
          cell_occ[it.cell_x][it.cell_y] = it.occupied;
          if (it.occupied) begin
            if (!found || it.cell_x < min_x) min_x = it.cell_x;
            if (!found || it.cell_x > max_x) max_x = it.cell_x;
            if (!found || it.cell_y < min_y) min_y = it.cell_y;
            if (!found || it.cell_y > max_y) max_y = it.cell_y;
            found = 1'b1;
          end
        end
      end
      OP_QUERY: pending_masks.push_back(predict_mask(it.cell_x, it.cell_y));
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      clear_box();
      regs.grid_width    = 7'd64;
      regs.grid_height   = 7'd64;
      regs.margin_x_low  = 4'd1;
      regs.margin_x_high = 4'd1;
      regs.margin_y_low  = 4'd1;
      regs.margin_y_high = 4'd2;
      pending_masks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GRID_WIDTH:    regs.grid_width    = cfg_wdata[EXTENT_W-1:0];
          CFG_GRID_HEIGHT:   regs.grid_height   = cfg_wdata[EXTENT_W-1:0];
          CFG_MARGIN_X_LOW:  regs.margin_x_low  = cfg_wdata[MARGIN_W-1:0];
          CFG_MARGIN_X_HIGH: regs.margin_x_high = cfg_wdata[MARGIN_W-1:0];
          CFG_MARGIN_Y_LOW:  regs.margin_y_low  = cfg_wdata[MARGIN_W-1:0];
          CFG_MARGIN_Y_HIGH: regs.margin_y_high = cfg_wdata[MARGIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_masks.size() == 0) begin
          $display("%0t: unexpected result, got mask_bit=%b box_empty=%b",
                   $time, out_data.mask_bit, out_data.box_empty);
          fail_cnt++;
        end else begin
          want = pending_masks.pop_front();
          if (out_data.mask_bit !== want.mask_bit) begin
            $display("%0t: mask_bit mismatch, expected %b got %b",
                     $time, want.mask_bit, out_data.mask_bit);
            fail_cnt++;
          end
          if (out_data.box_empty !== want.box_empty) begin
            $display("%0t: box_empty mismatch, expected %b got %b",
                     $time, want.box_empty, out_data.box_empty);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) apply_item(in_data);
    end
    results_due <= pending_masks.size();
    mismatches  <= fail_cnt;
  end

endmodule

// ===== bench/tb_grid_bbox_margin_mask_unit.sv =====
// Top of the bench for grid_bbox_margin_mask_unit: clock, reset, config writes,
// directed and random items with sender gaps and receiver stalls, and the verdict.
// Depends on gbm_pkg, the block and bbox_mask_checker.
`timescale 1ns / 1ps

module tb_grid_bbox_margin_mask_unit;
  import gbm_pkg::*;

  localparam logic [1:0]           OP_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int results_due;
  int stall_pct;
  int hold_reqs;
  int send_gap_pct = 0;
  int grid_w_use = 64;
  int grid_h_use = 64;
  int items_sent = 0;
  bit written [0:63][0:63];

  always #4 clk = ~clk;

  grid_bbox_margin_mask_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  bbox_mask_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  function automatic bit on_grid(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    return (int'(x) < grid_w_use) && (int'(y) < grid_h_use);
  endfunction

  function automatic in_item_t mk(input logic [1:0] op, input int x, input int y,
                                  input bit occ);
    in_item_t it;
    it.op       = op;
    it.cell_x   = COORD_W'(x);
    it.cell_y   = COORD_W'(y);
    it.occupied = occ;
    return it;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int extent);
    if (extent > 0 && $urandom_range(99) < 85) return COORD_W'($urandom_range(extent - 1));
    return COORD_W'($urandom_range(63));
  endfunction

  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (it.op == OP_LOAD && on_grid(it.cell_x, it.cell_y)) written[it.cell_x][it.cell_y] = 1'b1;
  endtask

  // drain: hold the input idle until every query result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_t c);
    cfg_put(CFG_GRID_WIDTH, c.grid_width);
    cfg_put(CFG_GRID_HEIGHT, c.grid_height);
    cfg_put(CFG_MARGIN_X_LOW, {3'($urandom), c.margin_x_low});
    cfg_put(CFG_MARGIN_X_HIGH, {3'($urandom), c.margin_x_high});
    cfg_put(CFG_MARGIN_Y_LOW, {3'($urandom), c.margin_y_low});
    cfg_put(CFG_MARGIN_Y_HIGH, {3'($urandom), c.margin_y_high});
    cfg_put($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 7'($urandom));
    cfg_we <= 1'b0;
    grid_w_use = (c.grid_width > 64) ? 64 : int'(c.grid_width);
    grid_h_use = (c.grid_height > 64) ? 64 : int'(c.grid_height);
  endtask

  task automatic random_item();
    in_item_t it;
    int       r;
    r           = $urandom_range(99);
    it.cell_x   = pick_coord(grid_w_use);
    it.cell_y   = pick_coord(grid_h_use);
    it.occupied = ($urandom_range(99) < 30);
    if (r < 4) it.op = OP_CLEAR;
    else if (r < 6) it.op = OP_SPARE;
    else if (r < 46) it.op = OP_LOAD;
    else begin
      it.op = OP_QUERY;
      if (on_grid(it.cell_x, it.cell_y) && !written[it.cell_x][it.cell_y])
        send(mk(OP_LOAD, it.cell_x, it.cell_y, $urandom_range(99) < 30));
    end
    send(it);
  endtask

  initial begin
    int holds_done;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cfg_t c;
    int   ph;
    int   start;
    bit   mid_drained;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    stall_pct <= 0;
    hold_reqs <= 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(mk(OP_LOAD, 0, 0, 1'b0));
    send(mk(OP_QUERY, 0, 0, 1'b0));
    send(mk(OP_LOAD, 63, 63, 1'b1));
    send(mk(OP_LOAD, 62, 61, 1'b0));
    send(mk(OP_QUERY, 62, 61, 1'b1));
    send(mk(OP_LOAD, 62, 62, 1'b0));
    send(mk(OP_QUERY, 62, 62, 1'b0));
    send(mk(OP_QUERY, 63, 63, 1'b0));
    send(mk(OP_LOAD, 63, 63, 1'b0));
    send(mk(OP_QUERY, 63, 63, 1'b0));
    send(mk(OP_SPARE, 21, 42, 1'b1));
    send(mk(OP_CLEAR, 42, 21, 1'b1));
    send(mk(OP_QUERY, 62, 62, 1'b0));
    send(mk(OP_LOAD, 0, 0, 1'b1));
    send(mk(OP_LOAD, 1, 2, 1'b0));
    send(mk(OP_QUERY, 1, 2, 1'b0));
    send(mk(OP_LOAD, 2, 0, 1'b0));
    send(mk(OP_QUERY, 2, 0, 1'b0));
    send(mk(OP_LOAD, 42, 21, 1'b1));
    send(mk(OP_LOAD, 21, 42, 1'b0));
    send(mk(OP_QUERY, 21, 42, 1'b0));
    send(mk(OP_QUERY, 42, 21, 1'b0));
    settle();

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: c = '{7'd8, 7'd8, 4'd0, 4'd0, 4'd0, 4'd0};
        1: c = '{7'd64, 7'd64, 4'd15, 4'd15, 4'd15, 4'd15};
        2: c = '{7'd127, 7'd127, 4'd3, 4'd0, 4'd2, 4'd1};
        3: c = '{7'd1, 7'd1, 4'd15, 4'd0, 4'd0, 4'd15};
        4: c = '{7'd0, 7'd9, 4'd5, 4'd10, 4'd5, 4'd10};
        5: c = '{7'd5, 7'd64, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom)};
        default: begin
          c.grid_width    = 7'($urandom_range(1, 20));
          c.grid_height   = 7'($urandom_range(1, 20));
          c.margin_x_low  = 4'($urandom);
          c.margin_x_high = 4'($urandom);
          c.margin_y_low  = 4'($urandom);
          c.margin_y_high = 4'($urandom);
        end
      endcase
      write_cfg(c);
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct <= 0;  end
        1: begin send_gap_pct = 47; stall_pct <= 0;  end
        2: begin send_gap_pct = 0;  stall_pct <= 47; end
        default: begin send_gap_pct = 19; stall_pct <= 19; end
      endcase
      if (ph == 6) hold_reqs <= hold_reqs + 1;
      start       = items_sent;
      mid_drained = 1'b0;
      while (items_sent - start < 103) begin
        if (ph == 3 && !mid_drained && items_sent - start >= 50) begin
          settle();
          mid_drained = 1'b1;
        end
        random_item();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
